// File: src/clle_pkg.sv
// shared types, constants and helpers for the cursor linked list engine
// no dependencies; imported by clle_store and cursor_linked_list_engine_core
package clle_pkg;

    // node store geometry
    localparam int CAPACITY     = 32;
    localparam int PAYLOAD_BITS = 32;

    // fixed field widths of the request and response transactions
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 32;

    // payload bits actually kept in the store
    localparam int KEEP_W = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

    // node index carries one extra code for the null marker
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CAPACITY-1:0] used_vec_t;

    localparam idx_t NIL = IDX_W'(CAPACITY);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAN  = 3'd5;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] payload;
    } clle_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic                list_empty;
    } clle_rsp_t;

    // control from the sequencer into the node store
    typedef struct packed {
        logic              pay_we;
        addr_t             pay_waddr;
        logic [KEEP_W-1:0] pay_wdata;
        logic              pay_re;
        addr_t             pay_raddr;
        logic              link_we;
        addr_t             link_waddr;
        idx_t              link_wdata;
        logic              link_re;
        addr_t             link_raddr;
        logic              used_set;
        logic              used_clr;
        addr_t             used_addr;
        logic              used_wipe;
    } clle_store_req_t;

    // read data and occupancy back from the node store
    typedef struct packed {
        logic [KEEP_W-1:0] pay_rdata;
        idx_t              link_rdata;
        used_vec_t         used;
        idx_t              free_idx;
    } clle_store_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_LINK,
        S_INS_FIX,
        S_WALK,
        S_RM_FIX,
        S_GET_DATA,
        S_NEXT_DATA,
        S_RESP
    } clle_state_t;

    // index names an occupied node
    function automatic logic is_node(input idx_t i, input used_vec_t used);
        logic hit;
        hit = 1'b0;
        if (i < NIL)
        begin
            hit = used[i[ADDR_W-1:0]];
        end
        return hit;
    endfunction

endpackage

// File: src/cursor_linked_list_engine_core.sv
// top level of the cursor linked list engine: request sequencer, head and
// cursor registers, response register; uses clle_pkg and clle_store
//
// A singly linked list of up to CAPACITY (32) nodes with a head and a cursor.
// Each request transaction carries a kind (insert, remove, get, next,
// beginning, clean) and a payload; each one yields exactly one response
// transaction with a status, the data read by get or remove, and a flag that
// is high when the list is empty afterwards. Requests are handled one at a
// time: req_stall is low only while the sequencer is idle, and a response
// waiting in the output register does not hold off the next request. A
// remove runs a predecessor walk from the head, which makes one dependent
// read of the link memory per node visited. The payload and link memories
// are synchronous RAMs with separate read and write ports; the sequencer
// never reads and writes the same entry in one cycle, so no forwarding is
// needed. After reset the list is empty and no clearing pass is run: only
// occupied nodes are ever read.
module cursor_linked_list_engine_core
    import clle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  clle_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output clle_rsp_t rsp
);

    clle_state_t state_reg, state_next;

    // captured request
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [KEEP_W-1:0] pay_reg, pay_next;

    // list pointers
    idx_t head_reg, head_next;
    idx_t cursor_reg, cursor_next;

    // insert slot and walk state
    idx_t new_reg, new_next;
    idx_t p_reg, p_next;
    idx_t prev_reg, prev_next;
    idx_t steps_reg, steps_next;
    logic from_ram_reg, from_ram_next;
    logic found_reg, found_next;

    // pending result
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;

    // response register
    logic      rsp_valid_reg, rsp_valid_next;
    clle_rsp_t rsp_reg, rsp_next;

    clle_store_req_t st_ctl;
    clle_store_rsp_t st_stat;

    // decisions shared by the next-state and datapath blocks
    logic cur_ok;
    logic head_ok;
    logic ins_go;
    logic ins_link;
    idx_t p_cur;
    logic walk_stop;
    logic walk_hit;
    logic rsp_free;

    clle_store u_store (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (st_ctl),
        .stat (st_stat)
    );

    assign cur_ok  = is_node(cursor_reg, st_stat.used);
    assign head_ok = is_node(head_reg, st_stat.used);

    // insert goes ahead with a nonzero payload and a free slot
    assign ins_go   = (pay_reg != '0) && (st_stat.free_idx != NIL);
    // non-empty list: splice after the cursor, needs the cursor's link first
    assign ins_link = ins_go && cur_ok;

    // walk pointer: head on the first step, then the link just read
    assign p_cur     = from_ram_reg ? st_stat.link_rdata : p_reg;
    assign walk_stop = (steps_reg == NIL) || !is_node(p_cur, st_stat.used);
    assign walk_hit  = !walk_stop && (p_cur == cursor_reg);

    // output register may take a new result
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (kind_reg)
                    KIND_INSERT: state_next = ins_link ? S_INS_LINK : S_RESP;
                    KIND_REMOVE: state_next = cur_ok ? S_WALK : S_RESP;
                    KIND_GET:    state_next = cur_ok ? S_GET_DATA : S_RESP;
                    KIND_NEXT:   state_next = cur_ok ? S_NEXT_DATA : S_RESP;
                    default:     state_next = S_RESP;
                endcase
            end
            S_INS_LINK:  state_next = S_INS_FIX;
            S_INS_FIX:   state_next = S_RESP;
            S_WALK:
            begin
                if (walk_hit || walk_stop)
                begin
                    state_next = S_RM_FIX;
                end
            end
            S_RM_FIX:    state_next = S_RESP;
            S_GET_DATA:  state_next = S_RESP;
            S_NEXT_DATA: state_next = S_RESP;
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath, store control and register next values
    always_comb
    begin
        kind_next      = kind_reg;
        pay_next       = pay_reg;
        head_next      = head_reg;
        cursor_next    = cursor_reg;
        new_next       = new_reg;
        p_next         = p_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        from_ram_next  = from_ram_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        st_ctl         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    pay_next  = req.payload[KEEP_W-1:0];
                end
            end

            S_DISPATCH:
            begin
                status_next = ST_OK;
                data_next   = '0;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (pay_reg == '0)
                        begin
                            status_next = ST_BAD_ARG;
                        end
                        else if (st_stat.free_idx == NIL)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            st_ctl.pay_we    = 1'b1;
                            st_ctl.pay_waddr = st_stat.free_idx[ADDR_W-1:0];
                            st_ctl.pay_wdata = pay_reg;
                            st_ctl.used_set  = 1'b1;
                            st_ctl.used_addr = st_stat.free_idx[ADDR_W-1:0];
                            new_next         = st_stat.free_idx;
                            if (cur_ok)
                            begin
                                // fetch the cursor's successor for the splice
                                st_ctl.link_re    = 1'b1;
                                st_ctl.link_raddr = cursor_reg[ADDR_W-1:0];
                            end
                            else
                            begin
                                // first node of a new list
                                st_ctl.link_we    = 1'b1;
                                st_ctl.link_waddr = st_stat.free_idx[ADDR_W-1:0];
                                st_ctl.link_wdata = NIL;
                                head_next         = st_stat.free_idx;
                                cursor_next       = st_stat.free_idx;
                            end
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!cur_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            st_ctl.pay_re    = 1'b1;
                            st_ctl.pay_raddr = cursor_reg[ADDR_W-1:0];
                            p_next           = head_reg;
                            prev_next        = NIL;
                            steps_next       = '0;
                            from_ram_next    = 1'b0;
                        end
                    end
                    KIND_GET:
                    begin
                        if (!cur_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            st_ctl.pay_re    = 1'b1;
                            st_ctl.pay_raddr = cursor_reg[ADDR_W-1:0];
                        end
                    end
                    KIND_NEXT:
                    begin
                        if (!cur_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            st_ctl.link_re    = 1'b1;
                            st_ctl.link_raddr = cursor_reg[ADDR_W-1:0];
                        end
                    end
                    KIND_BEGIN:
                    begin
                        if (!head_ok)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cursor_next = head_reg;
                        end
                    end
                    KIND_CLEAN:
                    begin
                        st_ctl.used_wipe = 1'b1;
                        head_next        = NIL;
                        cursor_next      = NIL;
                    end
                    default:
                    begin
                        status_next = ST_BAD_ARG;
                    end
                endcase
            end

            S_INS_LINK:
            begin
                // new node inherits the cursor's successor
                st_ctl.link_we    = 1'b1;
                st_ctl.link_waddr = new_reg[ADDR_W-1:0];
                st_ctl.link_wdata = st_stat.link_rdata;
            end

            S_INS_FIX:
            begin
                st_ctl.link_we    = 1'b1;
                st_ctl.link_waddr = cursor_reg[ADDR_W-1:0];
                st_ctl.link_wdata = new_reg;
                cursor_next       = new_reg;
            end

            S_WALK:
            begin
                if (walk_hit)
                begin
                    // fetch the removed node's successor
                    found_next        = 1'b1;
                    st_ctl.link_re    = 1'b1;
                    st_ctl.link_raddr = cursor_reg[ADDR_W-1:0];
                end
                else if (walk_stop)
                begin
                    found_next = 1'b0;
                end
                else
                begin
                    st_ctl.link_re    = 1'b1;
                    st_ctl.link_raddr = p_cur[ADDR_W-1:0];
                    prev_next         = p_cur;
                    steps_next        = steps_reg + 1'b1;
                    from_ram_next     = 1'b1;
                end
            end

            S_RM_FIX:
            begin
                data_next        = DATA_W'(st_stat.pay_rdata);
                st_ctl.used_clr  = 1'b1;
                st_ctl.used_addr = cursor_reg[ADDR_W-1:0];
                if (found_reg)
                begin
                    if (prev_reg == NIL)
                    begin
                        // head removed, successor takes over
                        if (is_node(st_stat.link_rdata, st_stat.used)
                            && (st_stat.link_rdata != cursor_reg))
                        begin
                            head_next   = st_stat.link_rdata;
                            cursor_next = st_stat.link_rdata;
                        end
                        else
                        begin
                            head_next   = NIL;
                            cursor_next = NIL;
                        end
                    end
                    else
                    begin
                        st_ctl.link_we    = 1'b1;
                        st_ctl.link_waddr = prev_reg[ADDR_W-1:0];
                        st_ctl.link_wdata = st_stat.link_rdata;
                        cursor_next       = prev_reg;
                    end
                end
                else
                begin
                    // cursor unreachable from head: drop it, fall back to head or empty the list
                    if (head_ok && (head_reg != cursor_reg))
                    begin
                        cursor_next = head_reg;
                    end
                    else
                    begin
                        head_next   = NIL;
                        cursor_next = NIL;
                    end
                end
            end

            S_GET_DATA:
            begin
                data_next = DATA_W'(st_stat.pay_rdata);
            end

            S_NEXT_DATA:
            begin
                if (is_node(st_stat.link_rdata, st_stat.used))
                begin
                    cursor_next = st_stat.link_rdata;
                end
                else
                begin
                    status_next = ST_END;
                end
            end

            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.status     = status_reg;
                    rsp_next.data       = data_reg;
                    rsp_next.list_empty = !head_ok;
                    rsp_valid_next      = 1'b1;
                end
            end

            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            cursor_reg    <= NIL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pay_reg      <= pay_next;
        new_reg      <= new_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        from_ram_reg <= from_ram_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // cursor is null or names an occupied node
    a_cursor_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == NIL) || ((cursor_reg < NIL) && st_stat.used[cursor_reg[ADDR_W-1:0]]))
        else $error("cursor points at a free or invalid slot");

    // head is null or names an occupied node
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) || ((head_reg < NIL) && st_stat.used[head_reg[ADDR_W-1:0]]))
        else $error("head points at a free or invalid slot");

    // an empty list has no cursor
    a_empty_no_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) |-> (cursor_reg == NIL))
        else $error("cursor set while list is empty");

    // walk never runs past the store size
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (steps_reg <= NIL))
        else $error("predecessor walk overran the store");

    // a new response only comes out of the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside the response state");
`endif

endmodule

// File: src/clle_store.sv
// node store: payload and link memories with registered read data,
// occupancy flags and lowest-free-slot search; uses clle_pkg
module clle_store
    import clle_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  clle_store_req_t ctl,
    output clle_store_rsp_t stat
);

    logic [KEEP_W-1:0] pay_mem [CAPACITY];
    idx_t              link_mem [CAPACITY];

    logic [KEEP_W-1:0] pay_rdata_reg;
    idx_t              link_rdata_reg;
    used_vec_t         used_reg;
    used_vec_t         used_next;
    idx_t              free_idx;

    always_ff @(posedge clk)
    begin
        if (ctl.pay_we)
        begin
            pay_mem[ctl.pay_waddr] <= ctl.pay_wdata;
        end
        if (ctl.pay_re)
        begin
            pay_rdata_reg <= pay_mem[ctl.pay_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[ctl.link_waddr] <= ctl.link_wdata;
        end
        if (ctl.link_re)
        begin
            link_rdata_reg <= link_mem[ctl.link_raddr];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (ctl.used_wipe)
        begin
            used_next = '0;
        end
        else if (ctl.used_set)
        begin
            used_next[ctl.used_addr] = 1'b1;
        end
        else if (ctl.used_clr)
        begin
            used_next[ctl.used_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // priority encoder, lowest free slot wins
    always_comb
    begin
        free_idx = NIL;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign stat.pay_rdata  = pay_rdata_reg;
    assign stat.link_rdata = link_rdata_reg;
    assign stat.used       = used_reg;
    assign stat.free_idx   = free_idx;

endmodule
